>>> src/checksum_packet_deframer_assert.svh
// Assertion macros shared by the deframer modules.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef CHECKSUM_PACKET_DEFRAMER_ASSERT_SVH
`define CHECKSUM_PACKET_DEFRAMER_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define CPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define CPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cpd_pkg.sv
// Shared types and constants for the checksum packet deframer.
// No dependencies; used by cpd_datapath, cpd_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int TIMEOUT_W = 16;
  localparam int OUT_IDX_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAYLOAD_LENGTH = 2'd0,
    CFG_TIMEOUT_TICKS  = 2'd1,
    CFG_HEADER_BYTE    = 2'd2,
    CFG_FOOTER_BYTE    = 2'd3
  } cfg_idx_t;

  localparam logic [LEN_W-1:0]     RST_PAYLOAD_LENGTH = 7'd8;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS  = 16'd100;
  localparam logic [BYTE_W-1:0]    RST_HEADER_BYTE    = 8'd64;
  localparam logic [BYTE_W-1:0]    RST_FOOTER_BYTE    = 8'd10;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
  } cpd_in_t;

  typedef struct packed {
    logic                 frame_ready;
    logic [BYTE_W-1:0]    payload_byte;
    logic [OUT_IDX_W-1:0] byte_index;
    logic                 last;
  } cpd_out_t;

  // controller -> datapath
  typedef struct packed {
    logic tick;        // bump idle counter
    logic byte_seen;   // clear idle counter
    logic clr_frame;   // clear payload count and running sum
    logic wr_payload;  // store byte, add to sum, advance count
    logic rd_clr;      // restart delivery index
    logic rd_inc;      // advance delivery index
    logic mem_rd;      // read payload store into read register
    logic load_nr;     // load not-ready result
    logic load_data;   // load payload result from read register
  } cpd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic header_match;
    logic len_match;
    logic sum_match;
    logic footer_match;
    logic timed_out;
    logic count_done;
    logic last_idx;
    logic out_free;
  } cpd_status_t;

endpackage

`default_nettype wire

>>> src/cpd_datapath.sv
// Deframer datapath: config registers, counters, running sum, payload
// store and the result register. Depends on cpd_pkg and the assert header.
`timescale 1ns / 1ps
`default_nettype none

`include "checksum_packet_deframer_assert.svh"

module cpd_datapath #(
  parameter int MAX_PAYLOAD      = 64,
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire cpd_pkg::cpd_in_t                      in_data,
  input  wire logic                                  cfg_we,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [cpd_pkg::CFG_W-1:0]             cfg_wdata,
  input  wire logic                                  out_stall,
  input  wire cpd_pkg::cpd_cmd_t                     cmd,
  output cpd_pkg::cpd_status_t                       status,
  output logic                                       out_valid,
  output cpd_pkg::cpd_out_t                          out_data
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CMP_W = (TICK_COUNT_WIDTH > cpd_pkg::TIMEOUT_W) ?
                         TICK_COUNT_WIDTH : cpd_pkg::TIMEOUT_W;
  localparam logic [cpd_pkg::LEN_W-1:0] MAX_LEN = cpd_pkg::LEN_W'(MAX_PAYLOAD);
  localparam logic [cpd_pkg::LEN_W-1:0] ONE_LEN = cpd_pkg::LEN_W'(1);

  logic [cpd_pkg::LEN_W-1:0]     payload_length_r;
  logic [cpd_pkg::TIMEOUT_W-1:0] timeout_ticks_r;
  logic [cpd_pkg::BYTE_W-1:0]    header_byte_r;
  logic [cpd_pkg::BYTE_W-1:0]    footer_byte_r;

  logic [IDX_W-1:0]              count_r;
  logic [cpd_pkg::BYTE_W-1:0]    sum_r;
  logic [TICK_COUNT_WIDTH-1:0]   idle_r;
  logic [IDX_W-1:0]              rd_idx_r;
  logic [cpd_pkg::BYTE_W-1:0]    rdata_r;
  logic                          out_valid_r;
  cpd_pkg::cpd_out_t             out_r;

  logic [cpd_pkg::BYTE_W-1:0]    store [MAX_PAYLOAD];

  logic [cpd_pkg::LEN_W-1:0]     len_eff;
  logic                          count_done;

  // length held within 1..MAX_PAYLOAD
  always_comb begin
    priority if (payload_length_r == '0) begin
      len_eff = ONE_LEN;
    end else if (payload_length_r > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = payload_length_r;
    end
  end

  assign count_done = cpd_pkg::LEN_W'(count_r) >= (len_eff - ONE_LEN);

  always_comb begin
    status.header_match = in_data.rx_byte == header_byte_r;
    status.len_match    = in_data.rx_byte == {1'b0, len_eff};
    status.sum_match    = in_data.rx_byte == sum_r;
    status.footer_match = in_data.rx_byte == footer_byte_r;
    status.timed_out    = CMP_W'(idle_r) > CMP_W'(timeout_ticks_r);
    status.count_done   = count_done;
    status.last_idx     = cpd_pkg::LEN_W'(rd_idx_r) == (len_eff - ONE_LEN);
    status.out_free     = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_length_r <= cpd_pkg::RST_PAYLOAD_LENGTH;
      timeout_ticks_r  <= cpd_pkg::RST_TIMEOUT_TICKS;
      header_byte_r    <= cpd_pkg::RST_HEADER_BYTE;
      footer_byte_r    <= cpd_pkg::RST_FOOTER_BYTE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpd_pkg::CFG_PAYLOAD_LENGTH: payload_length_r <= cfg_wdata[cpd_pkg::LEN_W-1:0];
        cpd_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks_r  <= cfg_wdata;
        cpd_pkg::CFG_HEADER_BYTE:    header_byte_r    <= cfg_wdata[cpd_pkg::BYTE_W-1:0];
        cpd_pkg::CFG_FOOTER_BYTE:    footer_byte_r    <= cfg_wdata[cpd_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.clr_frame) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.wr_payload) begin
      sum_r   <= sum_r + in_data.rx_byte;
      count_r <= count_done ? '0 : count_r + 1'b1;
    end
  end

  // saturating idle tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= '0;
    end else if (cmd.byte_seen) begin
      idle_r <= '0;
    end else if (cmd.tick && (idle_r != '1)) begin
      idle_r <= idle_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_clr) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_inc) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_payload) begin
      store[count_r] <= in_data.rx_byte;
    end
    if (cmd.mem_rd) begin
      rdata_r <= store[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_nr || cmd.load_data) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_nr) begin
      out_r.frame_ready  <= 1'b0;
      out_r.payload_byte <= '0;
      out_r.byte_index   <= '0;
      out_r.last         <= 1'b1;
    end else if (cmd.load_data) begin
      out_r.frame_ready  <= 1'b1;
      out_r.payload_byte <= rdata_r;
      out_r.byte_index   <= cpd_pkg::OUT_IDX_W'(rd_idx_r);
      out_r.last         <= status.last_idx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CPD_ASSERT_NEXT(a_nr_result, cmd.load_nr,
    out_valid_r && !out_r.frame_ready && out_r.last, "not-ready result malformed")
  `CPD_ASSERT_NEXT(a_data_result, cmd.load_data,
    out_valid_r && out_r.frame_ready, "payload result not marked ready")
  `CPD_ASSERT_NEXT(a_payload_wrap, cmd.wr_payload && !cmd.clr_frame && count_done,
    count_r == '0, "payload count did not wrap at end of payload")

endmodule

`default_nettype wire

>>> src/cpd_ctrl.sv
// Deframer controller: frame state machine and delivery sequencer.
// Drives cpd_cmd_t to the datapath from cpd_status_t; depends on cpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "checksum_packet_deframer_assert.svh"

module cpd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_op,
  input  wire cpd_pkg::cpd_status_t  status,
  output logic                       in_stall,
  output cpd_pkg::cpd_cmd_t          cmd
);

  typedef enum logic [4:0] {
    F_HEADER   = 5'b00001,
    F_LENGTH   = 5'b00010,
    F_PAYLOAD  = 5'b00100,
    F_CHECKSUM = 5'b01000,
    F_FOOTER   = 5'b10000
  } frame_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_READ = 3'b010,
    SQ_SEND = 3'b100
  } seq_state_t;

  frame_state_t frame_r, frame_nxt, frame_eff;
  seq_state_t   seq_r, seq_nxt;
  logic         in_accept;
  logic         timeout_hit;
  logic         deliver;

  assign in_stall    = !((seq_r == SQ_IDLE) && status.out_free);
  assign in_accept   = in_valid && !in_stall;
  assign timeout_hit = (frame_r != F_HEADER) && status.timed_out;
  // an expired frame is dropped before the byte is looked at
  assign frame_eff   = timeout_hit ? F_HEADER : frame_r;

  always_comb begin
    cmd       = '0;
    frame_nxt = frame_r;
    seq_nxt   = seq_r;
    deliver   = 1'b0;
    unique case (seq_r)
      SQ_IDLE: begin
        if (in_accept) begin
          if (in_op == cpd_pkg::OP_TICK) begin
            cmd.tick    = 1'b1;
            cmd.load_nr = 1'b1;
          end else begin
            cmd.byte_seen = 1'b1;
            cmd.clr_frame = timeout_hit;
            unique case (frame_eff)
              F_LENGTH: begin
                cmd.clr_frame = 1'b1;
                frame_nxt = status.len_match ? F_PAYLOAD : F_HEADER;
              end
              F_PAYLOAD: begin
                cmd.wr_payload = 1'b1;
                if (status.count_done) begin
                  frame_nxt = F_CHECKSUM;
                end
              end
              F_CHECKSUM: begin
                if (status.sum_match) begin
                  frame_nxt = F_FOOTER;
                end else begin
                  frame_nxt     = F_HEADER;
                  cmd.clr_frame = 1'b1;
                end
              end
              F_FOOTER: begin
                frame_nxt     = F_HEADER;
                cmd.clr_frame = 1'b1;
                deliver       = status.footer_match;
              end
              default: begin
                frame_nxt = status.header_match ? F_LENGTH : F_HEADER;
              end
            endcase
            if (deliver) begin
              cmd.rd_clr = 1'b1;
              seq_nxt    = SQ_READ;
            end else begin
              cmd.load_nr = 1'b1;
            end
          end
        end
      end
      SQ_READ: begin
        cmd.mem_rd = 1'b1;
        seq_nxt    = SQ_SEND;
      end
      SQ_SEND: begin
        if (status.out_free) begin
          cmd.load_data = 1'b1;
          if (status.last_idx) begin
            seq_nxt = SQ_IDLE;
          end else begin
            cmd.rd_inc = 1'b1;
            seq_nxt    = SQ_READ;
          end
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= F_HEADER;
      seq_r   <= SQ_IDLE;
    end else begin
      frame_r <= frame_nxt;
      seq_r   <= seq_nxt;
    end
  end

  `CPD_ASSERT_NEXT(a_footer_delivers,
    in_accept && (in_op == cpd_pkg::OP_BYTE) && (frame_r == F_FOOTER) && !timeout_hit &&
    status.footer_match,
    (seq_r == SQ_READ) && (frame_r == F_HEADER), "good footer did not start delivery")
  `CPD_ASSERT_NEXT(a_last_ends_delivery,
    (seq_r == SQ_SEND) && status.out_free && status.last_idx,
    seq_r == SQ_IDLE, "delivery did not end on last byte")
  `CPD_ASSERT_NEXT(a_timeout_abandons,
    in_accept && (in_op == cpd_pkg::OP_BYTE) && timeout_hit && !status.header_match,
    frame_r == F_HEADER, "expired frame not abandoned")

endmodule

`default_nettype wire

>>> src/checksum_packet_deframer.sv
// Checksum packet deframer top level: controller plus datapath.
// Depends on cpd_pkg, cpd_ctrl and cpd_datapath.
//
// Takes received bytes and time ticks one request at a time and checks the
// frame header, length, payload, 8-bit sum checksum and footer. A byte or
// tick is taken whenever the result register is free and no delivery
// runs, and yields one not-ready result. A good footer instead delivers
// the stored payload: for each byte the payload store is read into the
// read register, then the result register is loaded once it is free, so
// no new request is taken until the last payload byte is loaded. The
// payload store needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module checksum_packet_deframer #(
  parameter int MAX_PAYLOAD      = 64,
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire cpd_pkg::cpd_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output cpd_pkg::cpd_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cpd_pkg::CFG_W-1:0]       cfg_wdata
);

  cpd_pkg::cpd_cmd_t    cmd;
  cpd_pkg::cpd_status_t status;

  cpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  cpd_datapath #(
    .MAX_PAYLOAD      (MAX_PAYLOAD),
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> bench/checksum_packet_deframer_tb.sv
// Self-checking bench for checksum_packet_deframer: directed table, then random frames.
// Depends on cpd_pkg and the checksum_packet_deframer RTL; predicts results in its own model.
`timescale 1ns / 1ps

module checksum_packet_deframer_tb;
  import cpd_pkg::*;

  localparam int MAX_PAYLOAD = 64;
  localparam cpd_out_t NR_RESULT = '{1'b0, 8'h00, 6'd0, 1'b1};

  typedef enum logic [2:0] {
    AT_HUNT   = 3'd0,
    AT_LENGTH = 3'd1,
    AT_BODY   = 3'd2,
    AT_CHECK  = 3'd3,
    AT_TAIL   = 3'd4
  } frame_at_t;

  typedef enum int {FLAW_NONE, FLAW_LENGTH, FLAW_SUM, FLAW_FOOTER, FLAW_STALE} frame_flaw_t;

  typedef struct packed {
    cpd_in_t  req;
    logic     typed;
    cpd_out_t want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cpd_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  cpd_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // predictor state and register copies
  logic [LEN_W-1:0]     cfg_len;
  logic [TIMEOUT_W-1:0] cfg_timeout;
  logic [BYTE_W-1:0]    cfg_header;
  logic [BYTE_W-1:0]    cfg_footer;
  frame_at_t            frame_at;
  logic [LEN_W-1:0]     body_count;
  logic [BYTE_W-1:0]    run_sum;
  logic [BYTE_W-1:0]    body_store [MAX_PAYLOAD];
  logic [TIMEOUT_W-1:0] idle_ticks;

  cpd_out_t results_due [$];
  cpd_out_t step_results [$];
  int       requests_sent = 0;
  int       mismatches = 0;
  bit       send_idle = 1'b1;
  bit       recv_idle = 1'b1;
  bit       hold_req = 1'b0;

  // reset settings, typed expectations only for single not-ready results
  stim_row_t dir_rows [18] = '{
    '{'{OP_TICK, 8'hA5}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h00}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h40}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h08}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'hFF}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h00}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h80}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h01}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h7F}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'hFE}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h55}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'hAA}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'hFC}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h0A}, 1'b0, NR_RESULT},
    '{'{OP_BYTE, 8'h40}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'hFF}, 1'b1, NR_RESULT},
    '{'{OP_TICK, 8'h5A}, 1'b1, NR_RESULT},
    '{'{OP_BYTE, 8'h40}, 1'b1, NR_RESULT}
  };

  checksum_packet_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("checksum_packet_deframer: mismatch");
    $finish;
  end

  function automatic int frame_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > MAX_PAYLOAD) return MAX_PAYLOAD;
    return int'(cfg_len);
  endfunction

  task automatic drop_frame();
    frame_at = AT_HUNT;
    body_count = '0;
    run_sum = '0;
  endtask

  task automatic deframe_step(input cpd_in_t req);
    int len;
    len = frame_len();
    step_results.delete();
    if (req.op == OP_TICK) begin
      if (idle_ticks != '1) idle_ticks = idle_ticks + 1'b1;
    end else begin
      if (frame_at != AT_HUNT && idle_ticks > cfg_timeout) drop_frame();
      idle_ticks = '0;
      case (frame_at)
        AT_LENGTH: begin
          if (req.rx_byte == len) begin
            frame_at = AT_BODY;
            body_count = '0;
            run_sum = '0;
          end else begin
            drop_frame();
          end
        end
        AT_BODY: begin
          if (body_count < MAX_PAYLOAD) body_store[body_count] = req.rx_byte;
          run_sum = run_sum + req.rx_byte;
          if (body_count < len - 1) begin
            body_count = body_count + 1'b1;
          end else begin
            body_count = '0;
            frame_at = AT_CHECK;
          end
        end
        AT_CHECK: begin
          if (req.rx_byte == run_sum) frame_at = AT_TAIL;
          else drop_frame();
        end
        AT_TAIL: begin
          drop_frame();
          if (req.rx_byte == cfg_footer) begin
            for (int i = 0; i < len; i++)
              step_results.push_back(cpd_out_t'{1'b1, body_store[i], 6'(i), i == len - 1});
          end
        end
        // unused codes behave like header hunting
        default: frame_at = (req.rx_byte == cfg_header) ? AT_LENGTH : AT_HUNT;
      endcase
    end
    if (step_results.size() == 0) step_results.push_back(NR_RESULT);
  endtask

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    cpd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        note_mismatch("result with none pending", int'(out_data), 0);
      end else begin
        want = results_due.pop_front();
        if (out_data.frame_ready !== want.frame_ready)
          note_mismatch("frame_ready", out_data.frame_ready, want.frame_ready);
        if (out_data.payload_byte !== want.payload_byte)
          note_mismatch("payload_byte", out_data.payload_byte, want.payload_byte);
        if (out_data.byte_index !== want.byte_index)
          note_mismatch("byte_index", out_data.byte_index, want.byte_index);
        if (out_data.last !== want.last)
          note_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = recv_idle && ($urandom_range(99) < 29);
      end
    end
  end

  task automatic push_request(input cpd_in_t req, input logic typed, input cpd_out_t want);
    if (send_idle) while ($urandom_range(99) < 29) @(negedge clk);
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall !== 1'b0);
    deframe_step(req);
    if (typed) results_due.push_back(want);
    else foreach (step_results[k]) results_due.push_back(step_results[k]);
    requests_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    push_request(cpd_in_t'{OP_BYTE, b}, 1'b0, NR_RESULT);
  endtask

  task automatic send_tick();
    push_request(cpd_in_t'{OP_TICK, 8'($urandom)}, 1'b0, NR_RESULT);
  endtask

  // ticks ahead of a frame byte; a stale gap exceeds the timeout
  task automatic lead_ticks(input bit stale);
    int n;
    if (stale) n = int'(cfg_timeout) + 1 + $urandom_range(0, 2);
    else if ($urandom_range(99) < 15) n = $urandom_range(0, (cfg_timeout < 3) ? cfg_timeout : 3);
    else n = 0;
    repeat (n) send_tick();
  endtask

  task automatic send_frame(input frame_flaw_t flaw);
    int len;
    int stale_at;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] flip;
    len = frame_len();
    sum = '0;
    flip = 8'($urandom_range(1, 255));
    stale_at = (flaw == FLAW_STALE) ? $urandom_range(1, len + 3) : -1;
    send_byte(cfg_header);
    lead_ticks(stale_at == 1);
    send_byte((flaw == FLAW_LENGTH) ? 8'(len) ^ flip : 8'(len));
    for (int pos = 0; pos < len; pos++) begin
      b = 8'($urandom);
      sum = sum + b;
      lead_ticks(stale_at == pos + 2);
      send_byte(b);
    end
    lead_ticks(stale_at == len + 2);
    send_byte((flaw == FLAW_SUM) ? sum ^ flip : sum);
    lead_ticks(stale_at == len + 3);
    send_byte((flaw == FLAW_FOOTER) ? cfg_footer ^ flip : cfg_footer);
  endtask

  task automatic random_traffic(input int n_items);
    int stop_at;
    int pick;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) send_frame(FLAW_NONE);
      else if (pick < 68) send_frame(FLAW_LENGTH);
      else if (pick < 76) send_frame(FLAW_SUM);
      else if (pick < 84) send_frame(FLAW_FOOTER);
      else if (pick < 90 && cfg_timeout <= 16) send_frame(FLAW_STALE);
      else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(9) == 0) send_byte(cfg_header);
          else push_request(cpd_in_t'(9'($urandom)), 1'b0, NR_RESULT);
        end
      end
    end
  endtask

  // bring the frame back to header hunting so a length change cannot
  // expose store entries that were never written
  task automatic close_frame();
    while (frame_at != AT_HUNT) begin
      case (frame_at)
        AT_LENGTH: send_byte(8'hFF);
        AT_BODY:   send_byte(8'($urandom));
        AT_CHECK:  send_byte(run_sum ^ 8'h01);
        default:   send_byte(cfg_footer ^ 8'h01);
      endcase
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      CFG_PAYLOAD_LENGTH: cfg_len = value[LEN_W-1:0];
      CFG_TIMEOUT_TICKS:  cfg_timeout = value[TIMEOUT_W-1:0];
      CFG_HEADER_BYTE:    cfg_header = value[BYTE_W-1:0];
      default:            cfg_footer = value[BYTE_W-1:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(input int len, input int timeout, input int hdr, input int ftr);
    close_frame();
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    // upper bits of the narrow registers are don't-care
    write_reg(CFG_PAYLOAD_LENGTH, {9'($urandom), 7'(len)});
    write_reg(CFG_TIMEOUT_TICKS, 16'(timeout));
    write_reg(CFG_HEADER_BYTE, {8'($urandom), 8'(hdr)});
    write_reg(CFG_FOOTER_BYTE, {8'($urandom), 8'(ftr)});
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cfg_len = RST_PAYLOAD_LENGTH;
    cfg_timeout = RST_TIMEOUT_TICKS;
    cfg_header = RST_HEADER_BYTE;
    cfg_footer = RST_FOOTER_BYTE;
    frame_at = AT_HUNT;
    body_count = '0;
    run_sum = '0;
    idle_ticks = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[r]) push_request(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);

    apply_settings(1, 0, 8'h00, 8'hFF);
    random_traffic(50);
    apply_settings(64, 65535, 8'hFF, 8'h00);
    random_traffic(30);
    // zero length clamps to one; receiver holds off while requests keep coming
    apply_settings(0, 3, $urandom_range(255), $urandom_range(255));
    hold_req = 1'b1;
    random_traffic(40);
    apply_settings(127, 2, $urandom_range(255), $urandom_range(255));
    random_traffic(30);

    send_idle = 1'b0;
    recv_idle = 1'b0;
    apply_settings($urandom_range(2, 12), $urandom_range(0, 8),
                   $urandom_range(255), $urandom_range(255));
    random_traffic(35);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (3) begin
      apply_settings($urandom_range(1, 12),
                     ($urandom_range(1) != 0) ? $urandom_range(0, 10) : $urandom_range(65535),
                     $urandom_range(255), $urandom_range(255));
      random_traffic(35);
    end

    while (results_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("checksum_packet_deframer: match");
    end else begin
      $display("checksum_packet_deframer: mismatch");
    end
    $finish;
  end

endmodule
